// File: rtl/core/efra_pkg.sv
// ----------------------------------------------------------------------------
// efra_pkg
// shared types and constants of the earliest free room allocator
// ----------------------------------------------------------------------------
package efra_pkg;

  localparam int ROOMS_DEF = 16;
  localparam int ROOMS_MAX = 256;

  localparam int TIME_W = 32;
  localparam int FREE_W = 40;
  localparam int CNT_W  = 32;
  localparam int ROOM_W = 4;
  localparam int CFG_W  = 5;
  localparam int IDX_W  = $clog2(ROOMS_MAX);

  localparam logic [FREE_W-1:0] FREE_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(ROOMS_DEF);

  localparam logic CMD_BOOK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // search packet that walks the row of room cells
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  pick_idx;
    logic [IDX_W-1:0]  early_idx;
    logic [FREE_W-1:0] early_time;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W-1:0]  best_cnt;
    logic [FREE_W-1:0] best_time;
  } scan_pkt_t;

  // write-back to the chosen room
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [FREE_W-1:0] free_time;
  } room_upd_t;

endpackage

// File: rtl/core/efra_book_if.sv
// ----------------------------------------------------------------------------
// efra_book_if
// request channel: booking or most-booked query
// ----------------------------------------------------------------------------
interface efra_book_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [efra_pkg::TIME_W-1:0] meeting_start;
  logic [efra_pkg::TIME_W-1:0] meeting_end;

  modport source (output valid, command, meeting_start, meeting_end, input ready);
  modport sink   (input valid, command, meeting_start, meeting_end, output ready);
endinterface

// File: rtl/core/efra_result_if.sv
// ----------------------------------------------------------------------------
// efra_result_if
// result channel: chosen room and its finish time
// ----------------------------------------------------------------------------
interface efra_result_if;
  logic                       valid;
  logic                       ready;
  logic [efra_pkg::ROOM_W-1:0] room_index;
  logic                       was_delayed;
  logic [efra_pkg::FREE_W-1:0] finish_time;
  logic                       is_query_answer;

  modport source (output valid, room_index, was_delayed, finish_time, is_query_answer,
                  input ready);
  modport sink   (input valid, room_index, was_delayed, finish_time, is_query_answer,
                  output ready);
endinterface

// File: rtl/core/efra_cell.sv
// ----------------------------------------------------------------------------
// efra_cell
// one room: holds free time and booking count, folds itself into the
// passing search packet and registers it for the next cell
// ----------------------------------------------------------------------------
module efra_cell #(
  parameter int ROOMS = efra_pkg::ROOMS_DEF,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd,
  input  logic [efra_pkg::TIME_W-1:0]           start,
  input  logic [$clog2(ROOMS+1)-1:0]            live,
  input  efra_pkg::room_upd_t                   upd,
  input  efra_pkg::scan_pkt_t                   pkt_in,
  output efra_pkg::scan_pkt_t                   pkt_out
);

  localparam int LW = $clog2(ROOMS + 1);
  localparam logic [efra_pkg::IDX_W-1:0] MY_IDX = efra_pkg::IDX_W'(IDX);

  logic [efra_pkg::FREE_W-1:0] free_time;
  logic [efra_pkg::CNT_W-1:0]  count;
  logic                        active;
  logic                        hit;
  efra_pkg::scan_pkt_t         pkt_next;

  assign active = (LW'(IDX) < live);
  assign hit    = upd.valid && (upd.idx == MY_IDX);

  always_comb begin
    pkt_next = pkt_in;
    if (pkt_in.valid && active) begin
      if (cmd == efra_pkg::CMD_BOOK) begin
        if (!pkt_in.found) begin
          if (free_time <= efra_pkg::FREE_W'(start)) begin
            pkt_next.found    = 1'b1;
            pkt_next.pick_idx = MY_IDX;
          end else if (IDX == 0 || free_time < pkt_in.early_time) begin
            pkt_next.early_time = free_time;
            pkt_next.early_idx  = MY_IDX;
          end
        end
      end else begin
        // room zero always seeds the running maximum
        if (IDX == 0 || count > pkt_in.best_cnt) begin
          pkt_next.best_cnt  = count;
          pkt_next.best_idx  = MY_IDX;
          pkt_next.best_time = free_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_time <= '0;
      count     <= '0;
    end else if (hit) begin
      free_time <= upd.free_time;
      if (count != efra_pkg::COUNT_MAX) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/earliest_free_room_allocator_core.sv
// ----------------------------------------------------------------------------
// earliest_free_room_allocator_core
// books meetings into a pool of rooms through a row of room cells
// ----------------------------------------------------------------------------
//
//  channel       dir   handshake        payload
//  book          in    valid / ready    command, meeting_start, meeting_end
//  result        out   valid / ready    room_index, was_delayed, finish_time,
//                                       is_query_answer
//  active_rooms  in    write enable     active_rooms_data (5 bits)
//
//  an accepted word launches a search packet into room cell 0; it moves one
//  cell per cycle along the row of ROOMS cells
//  the packet leaving the last cell is kept in hold, then the result is loaded;
//  the next word is taken only after that load, so one word is in work at a time
//  rst (synchronous) clears all free times and counts, active_rooms -> 16
//  a stalled result holds the finished search; book.ready stays low meanwhile
//
module earliest_free_room_allocator_core #(
  parameter int ROOMS = efra_pkg::ROOMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  efra_book_if.sink                    book,
  efra_result_if.source                result,
  input  logic                         active_rooms_we,
  input  logic [efra_pkg::CFG_W-1:0]   active_rooms_data
);

  localparam int LW = $clog2(ROOMS + 1);

  // one-hot sequencer
  typedef enum logic [2:0] {
    IDLE = 3'b001,
    SCAN = 3'b010,
    DONE = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;

  logic [efra_pkg::CFG_W-1:0]   active_rooms;
  logic [LW-1:0]                live;

  // word under work
  logic                         cmd;
  logic [efra_pkg::TIME_W-1:0]  start;
  logic [efra_pkg::TIME_W-1:0]  stop;

  // request as seen by the row: cell 0 works on it in the accept cycle
  logic                         scan_cmd;
  logic [efra_pkg::TIME_W-1:0]  scan_start;

  // search packet chain, slot 0 is the injection point
  efra_pkg::scan_pkt_t          chain [ROOMS+1];
  efra_pkg::scan_pkt_t          hold;
  efra_pkg::room_upd_t          upd;
  logic [ROOMS:0]               chain_valid;

  logic                         accept;
  logic                         load;
  logic [efra_pkg::TIME_W-1:0]  dur;
  logic [efra_pkg::FREE_W:0]    sum;
  logic [efra_pkg::FREE_W-1:0]  late_time;
  logic [efra_pkg::IDX_W-1:0]   pick;
  logic [efra_pkg::FREE_W-1:0]  finish;

  assign accept     = book.valid && book.ready;
  assign book.ready = (state == IDLE);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rooms <= efra_pkg::ACTIVE_RESET;
    end else if (active_rooms_we) begin
      active_rooms <= active_rooms_data;
    end
  end

  // zero acts as one room, anything above the pool acts as the full pool
  always_comb begin
    if (active_rooms == '0) begin
      live = LW'(1);
    end else if (int'(active_rooms) > ROOMS) begin
      live = LW'(ROOMS);
    end else begin
      live = LW'(active_rooms);
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= book.command;
      start <= book.meeting_start;
      stop  <= book.meeting_end;
    end
  end

  // the captured copy is not there yet while cell 0 takes the fresh packet
  assign scan_cmd   = accept ? book.command : cmd;
  assign scan_start = accept ? book.meeting_start : start;

  // inject a fresh packet on accept
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept;
  end

  genvar g;
  generate
    for (g = 0; g < ROOMS; g++) begin : g_room
      efra_cell #(
        .ROOMS (ROOMS),
        .IDX   (g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .cmd     (scan_cmd),
        .start   (scan_start),
        .live    (live),
        .upd     (upd),
        .pkt_in  (chain[g]),
        .pkt_out (chain[g+1])
      );
    end
    for (g = 0; g <= ROOMS; g++) begin : g_vld
      assign chain_valid[g] = chain[g].valid;
    end
  endgenerate

  // keep the finished packet until the result register is free
  always_ff @(posedge clk) begin
    if (chain[ROOMS].valid) begin
      hold <= chain[ROOMS];
    end
  end

  // postponed booking: earliest free time plus duration, saturating
  assign dur       = (stop >= start) ? (stop - start) : '0;
  assign sum       = {1'b0, hold.early_time} + (efra_pkg::FREE_W + 1)'(dur);
  assign late_time = sum[efra_pkg::FREE_W] ? efra_pkg::FREE_MAX : sum[efra_pkg::FREE_W-1:0];

  always_comb begin
    if (cmd == efra_pkg::CMD_QUERY) begin
      pick   = hold.best_idx;
      finish = hold.best_time;
    end else if (hold.found) begin
      pick   = hold.pick_idx;
      finish = efra_pkg::FREE_W'(stop);
    end else begin
      pick   = hold.early_idx;
      finish = late_time;
    end
  end

  assign load = (state == DONE) && (!result.valid || result.ready);

  // write back to the chosen room on booking only
  assign upd.valid     = load && (cmd == efra_pkg::CMD_BOOK);
  assign upd.idx       = pick;
  assign upd.free_time = finish;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: if (accept) state_next = SCAN;
      SCAN: if (chain[ROOMS].valid) state_next = DONE;
      DONE: if (load) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.room_index      <= efra_pkg::ROOM_W'(pick);
      result.was_delayed     <= (cmd == efra_pkg::CMD_BOOK) && !hold.found;
      result.finish_time     <= finish;
      result.is_query_answer <= (cmd == efra_pkg::CMD_QUERY);
    end
  end

  // at most one search in flight along the row
  a_one_packet: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one search packet in the room row");

  // a room found free takes the booking end, which fits in 32 bits
  a_free_finish: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.is_query_answer && !result.was_delayed
    |-> result.finish_time[efra_pkg::FREE_W-1:efra_pkg::TIME_W] == '0)
    else $error("free booking finish time wider than the end time");

  // a query never reports a postponement
  a_query_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_query_answer |-> !result.was_delayed)
    else $error("query answer flagged as delayed");

  // a new result only comes out of the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == DONE))
    else $error("result loaded outside the done state");

endmodule
